@@ design/sra_pkg.sv @@
// ----------------------------------------------------------------------------
// sra_pkg: shared types and constants of the shelf rectangle allocator
// Payload structs, request/status/register codes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package sra_pkg;

  localparam int unsigned DIM_W      = 13;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned HND_W      = 8;
  localparam int unsigned STS_W      = 3;
  localparam int unsigned MRG_W      = 4;
  localparam int unsigned QNT_W      = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned DIVN_W     = 14;
  localparam int unsigned FIND_W     = 16;

  localparam int unsigned MaxDim         = 4096;
  localparam int unsigned DEF_MAX_STRIPS = 64;
  localparam int unsigned DEF_MAX_SLOTS  = 256;

  localparam logic [DIM_W-1:0] RST_ATLAS_W = 13'd2048;
  localparam logic [DIM_W-1:0] RST_ATLAS_H = 13'd2048;
  localparam logic [MRG_W-1:0] RST_MARGIN  = 4'd1;
  localparam logic [QNT_W-1:0] RST_QUANTUM = 7'd10;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATLAS_W = 2'd0,
    CFG_ATLAS_H = 2'd1,
    CFG_MARGIN  = 2'd2,
    CFG_QUANTUM = 2'd3
  } cfg_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK         = 3'd0,
    STS_FULL       = 3'd1,
    STS_TOO_LARGE  = 3'd2,
    STS_POOL_EMPTY = 3'd3,
    STS_BAD_HANDLE = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_FIND,
    S_SNEXT,
    S_SCHK,
    S_WCUR_RD,
    S_WCUR,
    S_WNX,
    S_FIT,
    S_LINK,
    S_NEW,
    S_NEWCHK,
    S_NEWWR,
    S_FREE,
    S_UNLINK,
    S_FSTRIP,
    S_POP,
    S_POPCHK,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [DIM_W-1:0] item_width;
    logic [DIM_W-1:0] item_height;
    logic [HND_W-1:0] slot_handle;
  } req_t;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [POS_W-1:0] place_x;
    logic [POS_W-1:0] place_y;
    logic [HND_W-1:0] granted_handle;
    logic [DIM_W-1:0] row_height;
  } res_t;

endpackage

`default_nettype wire

@@ design/sra_qdiv.sv @@
// ----------------------------------------------------------------------------
// sra_qdiv: iterative remainder unit
// Restoring division, one quotient bit per cycle; returns num mod den.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_qdiv (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [sra_pkg::DIVN_W-1:0]  num_i,
  input  wire logic [sra_pkg::QNT_W-1:0]   den_i,
  output logic                             done_o,
  output logic [sra_pkg::QNT_W-1:0]        rem_o
);

  localparam int unsigned CNT_W = $clog2(sra_pkg::DIVN_W + 1);

  logic                          run_q, run_d;
  logic                          done_q, done_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [sra_pkg::DIVN_W-1:0]    dvd_q, dvd_d;
  logic [sra_pkg::QNT_W-1:0]     rem_q, rem_d;
  logic [sra_pkg::QNT_W-1:0]     den_q, den_d;
  logic [sra_pkg::QNT_W:0]       trial;

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, dvd_q[sra_pkg::DIVN_W-1]};
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(sra_pkg::DIVN_W);
      dvd_d = num_i;
      rem_d = '0;
      den_d = den_i;
    end else if (run_q) begin
      // shift in one dividend bit, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = sra_pkg::QNT_W'(trial - {1'b0, den_q});
      end else begin
        rem_d = trial[sra_pkg::QNT_W-1:0];
      end
      dvd_d = {dvd_q[sra_pkg::DIVN_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ design/shelf_rect_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// shelf_rect_allocator_unit: shelf (strip) rectangle allocator for one atlas
// Allocate, free and clear requests on a strip table and linked slot lists.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats enter on in_valid_i / in_stall_o, one result beat per
//   request leaves on out_valid_o / out_stall_i. A beat moves at a rising
//   edge with valid high and stall low. The block works on one request at a
//   time; in_stall_o stays high from the beat until its result is loaded
//   into the output register, so a new request is taken while the previous
//   result still waits there.
//   Request steps, in order:
//     clear / unused type: straight to the result.  free: a bad handle
//     goes straight to the result; else unlink the slot and update its
//     strip head, then pop trailing empty strips until the table empties
//     or a live strip stays at the end.
//     allocate: round the height and check the size (remainder unit on a
//     14-bit dividend), a free-slot scan (16 busy bits a cycle), a walk
//     over strips and the slots of a matching strip (one slot memory read
//     port), then place the rectangle or open a strip and load the result.
//   Apply configuration writes (cfg_we_i) only while idle; they take effect
//   at the next edge.
//   Reset empties the strip table and marks every slot free; stored strip
//   and slot entries are left as they are and only read once live.
//   While the receiver stalls the result holds and the next request stops
//   at its last step until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module shelf_rect_allocator_unit #(
  parameter int unsigned MAX_STRIPS = sra_pkg::DEF_MAX_STRIPS,
  parameter int unsigned MAX_SLOTS  = sra_pkg::DEF_MAX_SLOTS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [sra_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [sra_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire sra_pkg::req_t                   in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output sra_pkg::res_t                        out_data_o
);

  localparam int unsigned SW  = $clog2(MAX_SLOTS);
  localparam int unsigned LW  = SW + 1;
  localparam int unsigned TW  = $clog2(MAX_STRIPS);
  localparam int unsigned CW  = TW + 1;
  localparam int unsigned NCH = (MAX_SLOTS + sra_pkg::FIND_W - 1) / sra_pkg::FIND_W;
  localparam int unsigned CHW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned PW  = $clog2(sra_pkg::FIND_W);
  localparam logic [LW-1:0] NIL = LW'(MAX_SLOTS);

  // configuration
  logic [sra_pkg::DIM_W-1:0] aw_q, ah_q;
  logic [sra_pkg::MRG_W-1:0] m_q;
  logic [sra_pkg::QNT_W-1:0] qt_q;

  sra_pkg::state_e state_q, state_d;
  sra_pkg::req_t   req_q, req_d;
  sra_pkg::res_t   res_q, res_d;
  sra_pkg::res_t   out_q;
  logic            out_valid_q, out_valid_d;

  logic [sra_pkg::DIVN_W-1:0] sh_q, sh_d;
  logic [SW-1:0]              f_q, f_d;
  logic [CW-1:0]              s_q, s_d;
  logic [LW-1:0]              cur_q, cur_d;
  logic [LW-1:0]              nx_q, nx_d;
  logic [14:0]                left_q, left_d;
  logic [sra_pkg::DIM_W-1:0]  right_q, right_d;
  logic [sra_pkg::DIM_W-1:0]  top_q, top_d;
  logic [CHW-1:0]             chunk_q, chunk_d;
  logic [CW-1:0]              count_q, count_d;
  logic [MAX_SLOTS-1:0]       busy_q, busy_d;

  // slot memories
  logic [sra_pkg::DIM_W-1:0] left_mem [MAX_SLOTS];
  logic [sra_pkg::DIM_W-1:0] span_mem [MAX_SLOTS];
  logic [LW-1:0]             next_mem [MAX_SLOTS];
  logic [LW-1:0]             prev_mem [MAX_SLOTS];
  logic [TW-1:0]             row_mem  [MAX_SLOTS];
  logic [sra_pkg::DIM_W-1:0] sl_left_rd, sl_span_rd;
  logic [LW-1:0]             sl_next_rd, sl_prev_rd;
  logic [TW-1:0]             sl_row_rd;
  logic [SW-1:0]             sl_raddr;
  logic                      fill_we;
  logic [sra_pkg::DIM_W-1:0] fill_left;
  logic [TW-1:0]             fill_row;
  logic                      nxm_we, pvm_we;
  logic [SW-1:0]             nxm_addr, pvm_addr;
  logic [LW-1:0]             nxm_data, pvm_data;

  // strip memories
  logic [sra_pkg::DIM_W-1:0] top_mem   [MAX_STRIPS];
  logic [sra_pkg::DIM_W-1:0] size_mem  [MAX_STRIPS];
  logic [LW-1:0]             first_mem [MAX_STRIPS];
  logic [sra_pkg::DIM_W-1:0] st_top_rd, st_size_rd;
  logic [LW-1:0]             st_first_rd;
  logic [TW-1:0]             st_raddr, st_waddr;
  logic                      st_we;
  logic [sra_pkg::DIM_W-1:0] st_top_wd, st_size_wd;
  logic [LW-1:0]             st_first_wd;

  // height rounding
  logic                      div_start, div_done;
  logic [sra_pkg::QNT_W-1:0] div_rem, q_eff;
  logic [sra_pkg::DIM_W-1:0] hh_raw;
  logic [sra_pkg::DIM_W-1:0] hh;
  logic [sra_pkg::DIVN_W-1:0] div_num;

  logic                      in_beat;
  logic [sra_pkg::DIM_W-1:0] w;
  logic [14:0]               w_m;
  logic                      too_large, fit, s_match, hd_ok;
  logic                      find_hit, last_chunk;
  logic [NCH*sra_pkg::FIND_W-1:0] busy_pad;
  logic [sra_pkg::FIND_W-1:0] chunk;
  logic [PW-1:0]             hit_pos;
  logic [SW-1:0]             free_idx;
  logic [14:0]               new_top;
  logic                      new_full;
  logic [SW-1:0]             hd_idx;
  logic [LW-1:0]             new_first;

  assign in_beat = in_valid_i && !in_stall_o;
  assign w       = req_q.item_width;
  assign w_m     = 15'(w) + 15'(m_q);
  assign q_eff   = (qt_q == '0) ? sra_pkg::QNT_W'(1) : qt_q;
  // the divider starts on the request beat, so take the height from the beat
  assign hh_raw  = (state_q == sra_pkg::S_IDLE) ? in_data_i.item_height : req_q.item_height;
  assign hh      = (hh_raw == '0) ? sra_pkg::DIM_W'(1) : hh_raw;
  assign div_num = sra_pkg::DIVN_W'(hh) + sra_pkg::DIVN_W'(q_eff) - 1'b1;

  sra_qdiv u_qdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (q_eff),
    .done_o  (div_done),
    .rem_o   (div_rem)
  );

  assign too_large = (32'(w) > sra_pkg::MaxDim) || (32'(sh_q) > sra_pkg::MaxDim) ||
                     (15'(aw_q) < w_m) || (16'(ah_q) < 16'(sh_q) + 16'(m_q));

  // free slot scan, 16 busy bits a cycle, padding reads as busy
  always_comb begin
    busy_pad = '1;
    busy_pad[MAX_SLOTS-1:0] = busy_q;
    chunk    = busy_pad[chunk_q*sra_pkg::FIND_W +: sra_pkg::FIND_W];
    find_hit = 1'b0;
    hit_pos  = '0;
    for (int i = sra_pkg::FIND_W - 1; i >= 0; i--) begin
      if (!chunk[i]) begin
        find_hit = 1'b1;
        hit_pos  = PW'(i);
      end
    end
  end
  assign free_idx   = SW'({chunk_q, hit_pos});
  assign last_chunk = (chunk_q == CHW'(NCH - 1));

  assign s_match  = (16'(st_size_rd) == 16'(sh_q));
  assign fit      = (15'(right_q) >= left_q) && ((15'(right_q) - left_q) >= w_m);
  assign new_top  = 15'(st_top_rd) + 15'(st_size_rd) + 15'(m_q);
  assign new_full = (16'(new_top) + 16'(sh_q) + 16'(m_q)) > 16'(ah_q);
  assign hd_idx   = SW'(req_q.slot_handle);
  assign hd_ok    = (32'(req_q.slot_handle) < MAX_SLOTS) && busy_q[hd_idx];
  assign new_first = (st_first_rd == LW'(hd_idx)) ? nx_q : st_first_rd;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sra_pkg::S_IDLE: begin
        if (in_beat) begin
          case (in_data_i.req_type)
            sra_pkg::REQ_ALLOC: state_d = sra_pkg::S_DIV;
            sra_pkg::REQ_FREE:  state_d = sra_pkg::S_FREE;
            default:            state_d = sra_pkg::S_EMIT;
          endcase
        end
      end
      sra_pkg::S_DIV:     if (div_done) state_d = sra_pkg::S_CHECK;
      sra_pkg::S_CHECK:   state_d = too_large ? sra_pkg::S_EMIT : sra_pkg::S_FIND;
      sra_pkg::S_FIND: begin
        if (find_hit) state_d = sra_pkg::S_SNEXT;
        else if (last_chunk) state_d = sra_pkg::S_EMIT;
      end
      sra_pkg::S_SNEXT:   state_d = (s_q >= count_q) ? sra_pkg::S_NEW : sra_pkg::S_SCHK;
      sra_pkg::S_SCHK: begin
        if (!s_match) state_d = sra_pkg::S_SNEXT;
        else if (st_first_rd >= NIL) state_d = sra_pkg::S_EMIT;
        else state_d = sra_pkg::S_WCUR_RD;
      end
      sra_pkg::S_WCUR_RD: state_d = sra_pkg::S_WCUR;
      sra_pkg::S_WCUR:    state_d = (sl_next_rd >= NIL) ? sra_pkg::S_FIT : sra_pkg::S_WNX;
      sra_pkg::S_WNX:     state_d = sra_pkg::S_FIT;
      sra_pkg::S_FIT: begin
        if (fit) state_d = sra_pkg::S_LINK;
        else if (nx_q >= NIL) state_d = sra_pkg::S_SNEXT;
        else state_d = sra_pkg::S_WCUR_RD;
      end
      sra_pkg::S_LINK:    state_d = sra_pkg::S_EMIT;
      sra_pkg::S_NEW: begin
        if (32'(count_q) >= MAX_STRIPS) state_d = sra_pkg::S_EMIT;
        else if (count_q == '0) state_d = sra_pkg::S_NEWWR;
        else state_d = sra_pkg::S_NEWCHK;
      end
      sra_pkg::S_NEWCHK:  state_d = new_full ? sra_pkg::S_EMIT : sra_pkg::S_NEWWR;
      sra_pkg::S_NEWWR:   state_d = sra_pkg::S_EMIT;
      sra_pkg::S_FREE:    state_d = hd_ok ? sra_pkg::S_UNLINK : sra_pkg::S_EMIT;
      sra_pkg::S_UNLINK:  state_d = sra_pkg::S_FSTRIP;
      sra_pkg::S_FSTRIP:  state_d = (new_first >= NIL) ? sra_pkg::S_POP : sra_pkg::S_EMIT;
      sra_pkg::S_POP:     state_d = (count_q == '0) ? sra_pkg::S_EMIT : sra_pkg::S_POPCHK;
      sra_pkg::S_POPCHK:  state_d = (st_first_rd >= NIL) ? sra_pkg::S_POP : sra_pkg::S_EMIT;
      sra_pkg::S_EMIT:    if (!out_valid_q || !out_stall_i) state_d = sra_pkg::S_IDLE;
      default:            state_d = sra_pkg::S_IDLE;
    endcase
  end

  // datapath registers
  always_comb begin
    req_d       = req_q;
    res_d       = res_q;
    sh_d        = sh_q;
    f_d         = f_q;
    s_d         = s_q;
    cur_d       = cur_q;
    nx_d        = nx_q;
    left_d      = left_q;
    right_d     = right_q;
    top_d       = top_q;
    chunk_d     = chunk_q;
    count_d     = count_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    case (state_q)
      sra_pkg::S_IDLE: begin
        if (in_beat) begin
          req_d = in_data_i;
          res_d = '0;
          if (in_data_i.req_type == sra_pkg::REQ_CLEAR) begin
            count_d = '0;
            busy_d  = '0;
          end
        end
      end
      sra_pkg::S_DIV: if (div_done) sh_d = div_num - sra_pkg::DIVN_W'(div_rem);
      sra_pkg::S_CHECK: begin
        chunk_d = '0;
        if (too_large) res_d.status = sra_pkg::STS_TOO_LARGE;
      end
      sra_pkg::S_FIND: begin
        if (find_hit) begin
          f_d = free_idx;
          s_d = '0;
        end else if (last_chunk) begin
          res_d.status = sra_pkg::STS_POOL_EMPTY;
        end else begin
          chunk_d = chunk_q + 1'b1;
        end
      end
      sra_pkg::S_SCHK: begin
        top_d = st_top_rd;
        cur_d = st_first_rd;
        if (!s_match) begin
          s_d = s_q + 1'b1;
        end else if (st_first_rd >= NIL) begin
          busy_d[f_q] = 1'b1;
          res_d.status         = sra_pkg::STS_OK;
          res_d.place_y        = st_top_rd[sra_pkg::POS_W-1:0];
          res_d.granted_handle = sra_pkg::HND_W'(f_q);
          res_d.row_height     = sh_q[sra_pkg::DIM_W-1:0];
        end
      end
      sra_pkg::S_WCUR: begin
        left_d  = 15'(sl_left_rd) + 15'(sl_span_rd) + 15'(m_q);
        nx_d    = sl_next_rd;
        right_d = aw_q;
      end
      sra_pkg::S_WNX: right_d = sl_left_rd;
      sra_pkg::S_FIT: begin
        if (fit) begin
          busy_d[f_q] = 1'b1;
          res_d.status         = sra_pkg::STS_OK;
          res_d.place_x        = left_q[sra_pkg::POS_W-1:0];
          res_d.place_y        = top_q[sra_pkg::POS_W-1:0];
          res_d.granted_handle = sra_pkg::HND_W'(f_q);
          res_d.row_height     = sh_q[sra_pkg::DIM_W-1:0];
        end else if (nx_q >= NIL) begin
          s_d = s_q + 1'b1;
        end else begin
          cur_d = nx_q;
        end
      end
      sra_pkg::S_NEW: begin
        top_d = '0;
        if (32'(count_q) >= MAX_STRIPS) res_d.status = sra_pkg::STS_FULL;
      end
      sra_pkg::S_NEWCHK: begin
        top_d = new_top[sra_pkg::DIM_W-1:0];
        if (new_full) res_d.status = sra_pkg::STS_FULL;
      end
      sra_pkg::S_NEWWR: begin
        count_d     = count_q + 1'b1;
        busy_d[f_q] = 1'b1;
        res_d.status         = sra_pkg::STS_OK;
        res_d.place_y        = top_q[sra_pkg::POS_W-1:0];
        res_d.granted_handle = sra_pkg::HND_W'(f_q);
        res_d.row_height     = sh_q[sra_pkg::DIM_W-1:0];
      end
      sra_pkg::S_FREE: if (!hd_ok) res_d.status = sra_pkg::STS_BAD_HANDLE;
      sra_pkg::S_UNLINK: begin
        nx_d           = sl_next_rd;
        busy_d[hd_idx] = 1'b0;
      end
      sra_pkg::S_POPCHK: if (st_first_rd >= NIL) count_d = count_q - 1'b1;
      sra_pkg::S_EMIT: begin
        if (!out_valid_q || !out_stall_i) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // memory strobes and handshake outputs
  always_comb begin
    div_start   = 1'b0;
    sl_raddr    = cur_q[SW-1:0];
    st_raddr    = s_q[TW-1:0];
    fill_we     = 1'b0;
    fill_left   = '0;
    fill_row    = s_q[TW-1:0];
    nxm_we      = 1'b0;
    nxm_addr    = f_q;
    nxm_data    = NIL;
    pvm_we      = 1'b0;
    pvm_addr    = f_q;
    pvm_data    = NIL;
    st_we       = 1'b0;
    st_waddr    = s_q[TW-1:0];
    st_top_wd   = st_top_rd;
    st_size_wd  = st_size_rd;
    st_first_wd = LW'(f_q);
    in_stall_o  = (state_q != sra_pkg::S_IDLE);
    case (state_q)
      sra_pkg::S_IDLE: begin
        div_start = in_beat && (in_data_i.req_type == sra_pkg::REQ_ALLOC);
      end
      sra_pkg::S_SCHK: begin
        if (s_match && (st_first_rd >= NIL)) begin
          // empty strip: place at its left edge
          st_we   = 1'b1;
          fill_we = 1'b1;
          nxm_we  = 1'b1;
          pvm_we  = 1'b1;
        end
      end
      sra_pkg::S_WCUR: sl_raddr = sl_next_rd[SW-1:0];
      sra_pkg::S_FIT: begin
        if (fit) begin
          fill_we   = 1'b1;
          fill_left = left_q[sra_pkg::DIM_W-1:0];
          nxm_we    = 1'b1;
          nxm_data  = nx_q;
          pvm_we    = 1'b1;
          pvm_data  = cur_q;
        end
      end
      sra_pkg::S_LINK: begin
        // splice the new slot after cur
        nxm_we   = 1'b1;
        nxm_addr = cur_q[SW-1:0];
        nxm_data = LW'(f_q);
        pvm_we   = (nx_q < NIL);
        pvm_addr = nx_q[SW-1:0];
        pvm_data = LW'(f_q);
      end
      sra_pkg::S_NEW: st_raddr = TW'(count_q - 1'b1);
      sra_pkg::S_NEWWR: begin
        st_we      = 1'b1;
        st_waddr   = count_q[TW-1:0];
        st_top_wd  = top_q;
        st_size_wd = sh_q[sra_pkg::DIM_W-1:0];
        fill_we    = 1'b1;
        fill_row   = count_q[TW-1:0];
        nxm_we     = 1'b1;
        pvm_we     = 1'b1;
      end
      sra_pkg::S_FREE: sl_raddr = hd_idx;
      sra_pkg::S_UNLINK: begin
        // drop the slot from its chain; hold the read on it for its row
        sl_raddr = hd_idx;
        nxm_we   = (sl_prev_rd < NIL);
        nxm_addr = sl_prev_rd[SW-1:0];
        nxm_data = sl_next_rd;
        pvm_we   = (sl_next_rd < NIL);
        pvm_addr = sl_next_rd[SW-1:0];
        pvm_data = sl_prev_rd;
        st_raddr = sl_row_rd;
      end
      sra_pkg::S_FSTRIP: begin
        st_raddr    = sl_row_rd;
        st_waddr    = sl_row_rd;
        st_we       = (st_first_rd == LW'(hd_idx));
        st_first_wd = nx_q;
      end
      sra_pkg::S_POP: st_raddr = TW'(count_q - 1'b1);
      default: ;
    endcase
  end

  // slot memories
  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      left_mem[f_q] <= fill_left;
      span_mem[f_q] <= w;
      row_mem[f_q]  <= fill_row;
    end
    if (nxm_we) next_mem[nxm_addr] <= nxm_data;
    if (pvm_we) prev_mem[pvm_addr] <= pvm_data;
    sl_left_rd <= left_mem[sl_raddr];
    sl_span_rd <= span_mem[sl_raddr];
    sl_next_rd <= next_mem[sl_raddr];
    sl_prev_rd <= prev_mem[sl_raddr];
    sl_row_rd  <= row_mem[sl_raddr];
  end

  // strip memories
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      top_mem[st_waddr]   <= st_top_wd;
      size_mem[st_waddr]  <= st_size_wd;
      first_mem[st_waddr] <= st_first_wd;
    end
    st_top_rd   <= top_mem[st_raddr];
    st_size_rd  <= size_mem[st_raddr];
    st_first_rd <= first_mem[st_raddr];
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sra_pkg::S_IDLE;
      count_q     <= '0;
      busy_q      <= '0;
      out_valid_q <= 1'b0;
      aw_q        <= sra_pkg::RST_ATLAS_W;
      ah_q        <= sra_pkg::RST_ATLAS_H;
      m_q         <= sra_pkg::RST_MARGIN;
      qt_q        <= sra_pkg::RST_QUANTUM;
      chunk_q     <= '0;
      s_q         <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      chunk_q     <= chunk_d;
      s_q         <= s_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sra_pkg::CFG_ATLAS_W: aw_q <= cfg_data_i;
          sra_pkg::CFG_ATLAS_H: ah_q <= cfg_data_i;
          sra_pkg::CFG_MARGIN:  m_q  <= cfg_data_i[sra_pkg::MRG_W-1:0];
          sra_pkg::CFG_QUANTUM: qt_q <= cfg_data_i[sra_pkg::QNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    res_q   <= res_d;
    sh_q    <= sh_d;
    f_q     <= f_d;
    cur_q   <= cur_d;
    nx_q    <= nx_d;
    left_q  <= left_d;
    right_q <= right_d;
    top_q   <= top_d;
    if (state_q == sra_pkg::S_EMIT && (!out_valid_q || !out_stall_i)) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the strip table never overflows
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= MAX_STRIPS) else $error("strip count above table size");

  // a request beat always makes the block busy on the next cycle
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> in_stall_o) else $error("request taken while still idle");

  // the slot being spliced in was marked busy by the fill step
  a_link_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sra_pkg::S_LINK) |-> busy_q[f_q]) else $error("linked slot not busy");

endmodule

`default_nettype wire

@@ dv/shelf_rect_allocator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// shelf_rect_allocator_unit_tb: self-checking bench for the shelf allocator
// A queue-fed driver sends allocate, free and clear beats in random bursts.
// An in-bench copy of the strip table and slot lists predicts each result.
// A monitor compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shelf_rect_allocator_unit_tb;

  localparam int unsigned NSTRIP = 64;
  localparam int unsigned NSLOT  = 256;
  localparam int unsigned NIL    = NSLOT;
  localparam int unsigned WATCHDOG_LIMIT = 200000;

  logic clk, rst_n;
  logic cfg_we;
  sra_pkg::cfg_e cfg_idx;
  logic [sra_pkg::CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_stall;
  sra_pkg::req_t in_data;
  logic out_valid, out_stall;
  sra_pkg::res_t out_data;

  shelf_rect_allocator_unit u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  // Shadow atlas state: registers, strip table, slot lists.
  int unsigned sh_aw, sh_ah, sh_margin, sh_quantum;
  int unsigned strip_y[NSTRIP], strip_h[NSTRIP], strip_head[NSTRIP];
  int unsigned n_strips;
  int unsigned slot_x[NSLOT], slot_w[NSLOT], slot_nx[NSLOT], slot_pv[NSLOT];
  int unsigned slot_strip[NSLOT];
  bit          slot_live[NSLOT];

  sra_pkg::req_t pending_reqs[$];
  sra_pkg::res_t expected_results[$];
  int   errors = 0;
  bit   hold_sender = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic sra_pkg::res_t make_res(sra_pkg::status_e st, int unsigned x,
                                             int unsigned y, int unsigned hd,
                                             int unsigned rh);
    sra_pkg::res_t r;
    r.status = st;
    r.place_x = x[sra_pkg::POS_W-1:0];
    r.place_y = y[sra_pkg::POS_W-1:0];
    r.granted_handle = hd[sra_pkg::HND_W-1:0];
    r.row_height = rh[sra_pkg::DIM_W-1:0];
    return r;
  endfunction

  function automatic void claim_slot(int unsigned f, int unsigned s, int unsigned x,
                                     int unsigned w, int unsigned p, int unsigned n);
    slot_live[f] = 1; slot_strip[f] = s; slot_x[f] = x;
    slot_w[f] = w; slot_pv[f] = p; slot_nx[f] = n;
  endfunction

  function automatic sra_pkg::res_t place_rect(int unsigned w, int unsigned h);
    int unsigned q, rh, f, top, cur, nx, lft, rgt, last;
    q = (sh_quantum == 0) ? 1 : sh_quantum;
    rh = (((h == 0) ? 1 : h) + q - 1) / q * q;
    if (w > sra_pkg::MaxDim || rh > sra_pkg::MaxDim || sh_aw < w + sh_margin ||
        sh_ah < rh + sh_margin)
      return make_res(sra_pkg::STS_TOO_LARGE, 0, 0, 0, 0);
    f = NSLOT;
    for (int i = NSLOT - 1; i >= 0; i--) if (!slot_live[i]) f = i;
    if (f == NSLOT) return make_res(sra_pkg::STS_POOL_EMPTY, 0, 0, 0, 0);
    for (int unsigned s = 0; s < n_strips; s++) begin
      if (strip_h[s] != rh) continue;
      cur = strip_head[s];
      if (cur == NIL) begin
        strip_head[s] = f;
        claim_slot(f, s, 0, w, NIL, NIL);
        return make_res(sra_pkg::STS_OK, 0, strip_y[s], f, rh);
      end
      while (cur != NIL) begin
        nx = slot_nx[cur];
        lft = slot_x[cur] + slot_w[cur] + sh_margin;
        rgt = (nx != NIL) ? slot_x[nx] : sh_aw;
        if (rgt >= lft && rgt - lft >= w + sh_margin) begin
          claim_slot(f, s, lft, w, cur, nx);
          if (nx != NIL) slot_pv[nx] = f;
          slot_nx[cur] = f;
          return make_res(sra_pkg::STS_OK, lft, strip_y[s], f, rh);
        end
        cur = nx;
      end
    end
    if (n_strips >= NSTRIP) return make_res(sra_pkg::STS_FULL, 0, 0, 0, 0);
    top = 0;
    if (n_strips != 0) begin
      last = n_strips - 1;
      top = strip_y[last] + strip_h[last] + sh_margin;
      if (top + rh + sh_margin > sh_ah) return make_res(sra_pkg::STS_FULL, 0, 0, 0, 0);
    end
    strip_y[n_strips] = top; strip_h[n_strips] = rh; strip_head[n_strips] = f;
    claim_slot(f, n_strips, 0, w, NIL, NIL);
    n_strips++;
    return make_res(sra_pkg::STS_OK, 0, top, f, rh);
  endfunction

  function automatic sra_pkg::res_t release_slot(int unsigned hd);
    int unsigned p, n, r;
    if (!slot_live[hd]) return make_res(sra_pkg::STS_BAD_HANDLE, 0, 0, 0, 0);
    p = slot_pv[hd]; n = slot_nx[hd]; r = slot_strip[hd];
    if (p != NIL) slot_nx[p] = n;
    if (n != NIL) slot_pv[n] = p;
    slot_live[hd] = 0;
    if (strip_head[r] == hd) strip_head[r] = n;
    // Pop trailing strips that are now empty.
    if (strip_head[r] == NIL)
      while (n_strips > 0 && strip_head[n_strips-1] == NIL) n_strips--;
    return make_res(sra_pkg::STS_OK, 0, 0, 0, 0);
  endfunction

  function automatic sra_pkg::res_t predict_request(sra_pkg::req_t rq);
    case (rq.req_type)
      sra_pkg::REQ_ALLOC: return place_rect(rq.item_width, rq.item_height);
      sra_pkg::REQ_FREE:  return release_slot(rq.slot_handle);
      sra_pkg::REQ_CLEAR: begin
        n_strips = 0;
        foreach (slot_live[i]) slot_live[i] = 0;
      end
      default: ;
    endcase
    return make_res(sra_pkg::STS_OK, 0, 0, 0, 0);
  endfunction

  function automatic void queue_req(sra_pkg::req_t r);
    pending_reqs = {pending_reqs, r};
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: bursts of random length, random gaps; hold payload while stalled.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (!(in_valid && in_stall)) begin
        if (hold_sender || pending_reqs.size() == 0) begin
          in_valid <= 0;
        end else if (gap_left > 0) begin
          in_valid <= 0;
          gap_left <= gap_left - 1;
        end else begin
          in_valid <= 1;
          in_data <= pending_reqs.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Predict at the accepting edge so the model sees beats in order.
  always @(posedge clk) begin
    sra_pkg::res_t exp_res;
    if (rst_n && in_valid && !in_stall) begin
      exp_res = predict_request(in_data);
      expected_results = {expected_results, exp_res};
    end
  end

  // Receiver stall pattern: phases of free run, light and heavy stalling.
  int stall_mode = 0, stall_phase = 0;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (stall_phase == 0) begin
        stall_phase <= $urandom_range(50, 400);
        stall_mode <= $urandom_range(0, 2);
      end else begin
        stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    sra_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status != want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.place_x != want.place_x)
          report_mismatch("place_x", out_data.place_x, want.place_x);
        if (out_data.place_y != want.place_y)
          report_mismatch("place_y", out_data.place_y, want.place_y);
        if (out_data.granted_handle != want.granted_handle)
          report_mismatch("granted_handle", out_data.granted_handle, want.granted_handle);
        if (out_data.row_height != want.row_height)
          report_mismatch("row_height", out_data.row_height, want.row_height);
      end
    end
  end

  // Watchdog: count cycles with no beat on either side.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic sra_pkg::req_t mk_req(sra_pkg::req_e t, int unsigned w,
                                           int unsigned h, int unsigned hd);
    sra_pkg::req_t r;
    r.req_type = t;
    r.item_width = w[sra_pkg::DIM_W-1:0];
    r.item_height = h[sra_pkg::DIM_W-1:0];
    r.slot_handle = hd[sra_pkg::HND_W-1:0];
    return r;
  endfunction

  // Free handles are drawn at random from 0 to 40, the low slots that fill first.
  function automatic sra_pkg::req_t random_req(int unsigned wmax, int unsigned hmax);
    int unsigned k;
    sra_pkg::req_t r;
    k = $urandom_range(0, 99);
    if (k < 62) begin
      r = mk_req(sra_pkg::REQ_ALLOC, $urandom_range(0, wmax), $urandom_range(0, hmax), 0);
    end else if (k < 92) begin
      r = mk_req(sra_pkg::REQ_FREE, $urandom_range(0, 8191), $urandom_range(0, 8191),
                 $urandom_range(0, 40));
    end else if (k < 94) begin
      r = mk_req(sra_pkg::REQ_CLEAR, 0, 0, 0);
    end else if (k < 96) begin
      r = mk_req(sra_pkg::REQ_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 8191),
                 $urandom_range(0, 255));
      r.req_type = 2'd3;
    end else begin
      // Full-range noise on the sizes to reach the too-large checks.
      r = mk_req(sra_pkg::REQ_ALLOC, $urandom_range(0, 8191), $urandom_range(0, 8191), 0);
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic write_reg(sra_pkg::cfg_e idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val[sra_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      sra_pkg::CFG_ATLAS_W: sh_aw = val & 13'h1FFF;
      sra_pkg::CFG_ATLAS_H: sh_ah = val & 13'h1FFF;
      sra_pkg::CFG_MARGIN:  sh_margin = val & 4'hF;
      default:              sh_quantum = val & 7'h7F;
    endcase
  endtask

  task automatic set_atlas(int unsigned aw, int unsigned ah, int unsigned m,
                           int unsigned q);
    write_reg(sra_pkg::CFG_ATLAS_W, aw);
    write_reg(sra_pkg::CFG_ATLAS_H, ah);
    write_reg(sra_pkg::CFG_MARGIN, m);
    write_reg(sra_pkg::CFG_QUANTUM, q);
  endtask

  initial begin
    int unsigned aw, ah;
    rst_n = 0;
    cfg_we = 0; cfg_idx = sra_pkg::CFG_ATLAS_W; cfg_data = '0;
    sh_aw = 2048; sh_ah = 2048; sh_margin = 1; sh_quantum = 10;
    n_strips = 0;
    foreach (slot_live[i]) slot_live[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset settings, size extremes, every request type.
    queue_req(mk_req(sra_pkg::REQ_FREE, 0, 0, 0));          // idle handle
    queue_req(mk_req(sra_pkg::REQ_FREE, 0, 0, 255));
    queue_req(mk_req(sra_pkg::REQ_ALLOC, 0, 0, 0));         // zero height
    queue_req(mk_req(sra_pkg::REQ_ALLOC, 30, 7, 0));        // same strip
    queue_req(mk_req(sra_pkg::REQ_ALLOC, 2047, 10, 0));     // too wide for strip 0: new strip
    queue_req(mk_req(sra_pkg::REQ_ALLOC, 2046, 11, 0));     // new strip
    queue_req(mk_req(sra_pkg::REQ_ALLOC, 8191, 8191, 0));
    queue_req(mk_req(sra_pkg::REQ_ALLOC, 4096, 4096, 0));
    queue_req(mk_req(sra_pkg::REQ_ALLOC, 10, 2040, 0));     // atlas full
    queue_req(mk_req(sra_pkg::REQ_FREE, 0, 0, 1));          // mid gap frees
    queue_req(mk_req(sra_pkg::REQ_ALLOC, 5, 3, 0));
    queue_req(mk_req(sra_pkg::REQ_FREE, 0, 0, 2));          // empties strip 1, not the last
    queue_req(mk_req(sra_pkg::REQ_FREE, 0, 0, 2));          // double free
    queue_req(mk_req(sra_pkg::REQ_CLEAR, 0, 0, 0));
    queue_req(mk_req(sra_pkg::REQ_ALLOC, 1, 1, 0));
    queue_req('1);                                          // unused type
    queue_req(mk_req(sra_pkg::REQ_CLEAR, 0, 0, 0));
    wait_drained();

    // Pool exhaustion: tiny rectangles fill all slots, then one more.
    set_atlas(4096, 4096, 0, 1);
    for (int i = 0; i < 257; i++) queue_req(mk_req(sra_pkg::REQ_ALLOC, 1, 1, 0));
    queue_req(mk_req(sra_pkg::REQ_CLEAR, 0, 0, 0));
    wait_drained();

    // Strip table full: 65 distinct heights, then a clear.
    for (int i = 1; i <= 65; i++) queue_req(mk_req(sra_pkg::REQ_ALLOC, 3, i, 0));
    queue_req(mk_req(sra_pkg::REQ_CLEAR, 0, 0, 0));
    wait_drained();

    // Random phases across settings, extremes included; quantum 0 acts as 1.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_atlas(2048, 2048, 1, 10);
        1: set_atlas(1, 1, 0, 1);
        2: set_atlas(8191, 8191, 15, 64);
        3: set_atlas(200, 300, 2, 0);
        4: set_atlas(4096, 4096, 15, 127);
        default: set_atlas($urandom_range(1, 4096), $urandom_range(1, 4096),
                           $urandom_range(0, 15), $urandom_range(1, 64));
      endcase
      aw = (sh_aw < 300) ? sh_aw + 4 : 300;
      ah = (sh_quantum > 20 ? 3 * sh_quantum : 60);
      for (int i = 0; i < 56; i++) queue_req(random_req(aw, ah));
      // Pause the sender until the block has answered everything.
      if (ph == 2) begin
        while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
        hold_sender = 1;
        while (expected_results.size() != 0) @(posedge clk);
        hold_sender = 0;
      end
      wait_drained();
      // Shrink the width with live slots so later gaps can go negative.
      if (ph == 6) begin
        write_reg(sra_pkg::CFG_ATLAS_W, sh_aw / 3 + 1);
        for (int i = 0; i < 60; i++) queue_req(random_req(80, 40));
        wait_drained();
      end
    end

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

@@ shelf_rect_allocator_unit.f @@
design/sra_pkg.sv
design/sra_qdiv.sv
design/shelf_rect_allocator_unit.sv
dv/shelf_rect_allocator_unit_tb.sv
